/* src/pressure_apogee_detector_assert.svh */
// Assertion macros for the checker file of the pressure apogee detector
`ifndef PRESSURE_APOGEE_DETECTOR_ASSERT_SVH
`define PRESSURE_APOGEE_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define PAD_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pad_checker: assertion failed");

// Next-cycle implication, disabled while reset is low
`define PAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pad_checker: assertion failed");

`endif

/* src/pad_pkg.sv */
// Shared widths, constants and register codes of the pressure apogee detector
`default_nettype none

package pad_pkg;

  // Field widths
  parameter int unsigned RAW_W      = 24;
  parameter int unsigned SCALED_W   = 20;
  parameter int unsigned CHANGE_W   = 21;
  parameter int unsigned COUNT_W    = 8;
  parameter int unsigned INTERVAL_W = 10;
  parameter int unsigned RISE_W     = 8;
  parameter int unsigned HALF_W     = 16;

  // Register port
  parameter int unsigned DATA_W    = 32;
  parameter int unsigned ADDR_W    = 4;
  parameter int unsigned REG_IDX_W = ADDR_W - 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SAMPLE_INTERVAL,
    REG_RISE_WINDOWS,
    REG_BLINK_HALF_PERIOD
  } pad_reg_e;

  // Register reset values
  parameter logic [INTERVAL_W-1:0] SAMPLE_INTERVAL_RST   = 10'd20;
  parameter logic [RISE_W-1:0]     RISE_WINDOWS_RST      = 8'd5;
  parameter logic [HALF_W-1:0]     BLINK_HALF_PERIOD_RST = 16'd500;

  // Raw word to hectopascal times 200: multiply by 200, drop 12 bits
  parameter int unsigned SCALE_MUL    = 200;
  parameter int unsigned SCALE_SHIFT  = 12;
  parameter int unsigned SCALE_PROD_W = 32;
  parameter int unsigned SCALED_LIMIT = 819200;

  // Saturation limits
  parameter logic [RISE_W-1:0]  RUN_MAX   = 8'hFF;
  parameter logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

  parameter int unsigned DEFAULT_WINDOW_SAMPLES = 10;

endpackage

`default_nettype wire

/* src/pad_if.sv */
// Valid/ready channel interfaces for the input tick and the result beat
`default_nettype none

interface pad_in_if
  import pad_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [RAW_W-1:0]  pressure_raw;
  logic              clear_event;

  modport source (output valid, pressure_raw, clear_event, input ready);
  modport sink   (input valid, pressure_raw, clear_event, output ready);
endinterface

interface pad_out_if
  import pad_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic [SCALED_W-1:0]        scaled_pressure;
  logic [SCALED_W-1:0]        window_average;
  logic signed [CHANGE_W-1:0] average_change;
  logic                       deploy_event;
  logic [COUNT_W-1:0]         deploy_count;
  logic                       led_out;
  logic                       motor_in1;
  logic                       motor_in2;

  modport source (output valid, scaled_pressure, window_average, average_change,
                  deploy_event, deploy_count, led_out, motor_in1, motor_in2,
                  input ready);
  modport sink   (input valid, scaled_pressure, window_average, average_change,
                  deploy_event, deploy_count, led_out, motor_in1, motor_in2,
                  output ready);
endinterface

`default_nettype wire

/* src/pressure_apogee_detector.sv */
// Top level of the pressure apogee detector: sampling, window average, rise run, blinker
//
//   channel  dir  handshake      beat contents
//   in_i     in   valid/ready    pressure_raw, clear_event (one millisecond tick)
//   out_o    out  valid/ready    scaled, average, change, event, count, pins
//   apb      in   psel/penable   sample_interval, rise_windows, blink_half_period
//
// One tick beat is taken every cycle unless a result beat waits on out_o; it passes the stages below.
// Stages: scale (constant multiply), window accumulate, reciprocal divide
// (one 23x28 multiply), then rise run, event and blinker into the result register.
// A result waiting on out_o freezes all four stages together; in_i.ready drops only then.
// Reset clears the valid flags and result state (not the stage A-C data); registers return to 20, 5 and 500.
`default_nettype none

module pressure_apogee_detector
  import pad_pkg::*;
#(
  parameter int unsigned WINDOW_SAMPLES = DEFAULT_WINDOW_SAMPLES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  pad_in_if.sink            in_i,
  pad_out_if.source         out_o
);

  localparam int unsigned SUM_W     = $clog2(WINDOW_SAMPLES * SCALED_LIMIT);
  localparam int unsigned IDX_W     = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam int unsigned DIV_SHIFT = SUM_W + $clog2(WINDOW_SAMPLES);
  localparam int unsigned PROD_W    = SUM_W + DIV_SHIFT + 1;
  localparam logic [63:0] RECIP_L   =
    ((64'd1 << DIV_SHIFT) + 64'(WINDOW_SAMPLES) - 64'd1) / 64'(WINDOW_SAMPLES);
  localparam logic [DIV_SHIFT:0] RECIP    = RECIP_L[DIV_SHIFT:0];
  localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(WINDOW_SAMPLES - 1);

  typedef struct packed {
    logic led;
    logic in1;
    logic in2;
  } pins_t;

  localparam pins_t PINS_DRIVE = '{led: 1'b1, in1: 1'b0, in2: 1'b1};
  localparam pins_t PINS_BRAKE = '{led: 1'b0, in1: 1'b1, in2: 1'b1};

  // Configuration registers
  logic [INTERVAL_W-1:0] sample_interval_q;
  logic [RISE_W-1:0]     rise_windows_q;
  logic [HALF_W-1:0]     blink_half_q;
  logic                  cfg_write;
  pad_reg_e              cfg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_sel   = pad_reg_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_interval_q <= SAMPLE_INTERVAL_RST;
      rise_windows_q    <= RISE_WINDOWS_RST;
      blink_half_q      <= BLINK_HALF_PERIOD_RST;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_SAMPLE_INTERVAL:   sample_interval_q <= pwdata[INTERVAL_W-1:0];
        REG_RISE_WINDOWS:      rise_windows_q    <= pwdata[RISE_W-1:0];
        REG_BLINK_HALF_PERIOD: blink_half_q      <= pwdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      REG_SAMPLE_INTERVAL:   prdata = DATA_W'(sample_interval_q);
      REG_RISE_WINDOWS:      prdata = DATA_W'(rise_windows_q);
      REG_BLINK_HALF_PERIOD: prdata = DATA_W'(blink_half_q);
      default:               prdata = '0;
    endcase
  end

  // Advance the whole pipeline unless a result beat is stuck
  logic out_valid_q;
  logic adv;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // ---------------- Stage A: sample phase and scaling ----------------
  logic [INTERVAL_W-1:0]   phase_q;
  logic [INTERVAL_W-1:0]   phase_d;
  logic [SCALE_PROD_W-1:0] scale_prod;
  logic [SCALED_W-1:0]     in_scaled;

  assign scale_prod = SCALE_PROD_W'(in_i.pressure_raw) * SCALE_PROD_W'(SCALE_MUL);
  assign in_scaled  = scale_prod[SCALE_SHIFT +: SCALED_W];

  // Wrap the phase once it reaches the interval minus one (zero acts as one)
  always_comb begin
    if ((INTERVAL_W + 1)'(phase_q) + 1'b1 >= (INTERVAL_W + 1)'(sample_interval_q)) begin
      phase_d = '0;
    end else begin
      phase_d = phase_q + 1'b1;
    end
  end

  logic                a_valid_q;
  logic                a_sample_q;
  logic                a_clear_q;
  logic [SCALED_W-1:0] a_scaled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= in_i.valid;
      if (in_i.valid) begin
        phase_q <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_sample_q <= (phase_q == '0);
      a_clear_q  <= in_i.clear_event;
      a_scaled_q <= in_scaled;
    end
  end

  // ---------------- Stage B: window accumulation ----------------
  logic [SUM_W-1:0] sum_q;
  logic [IDX_W-1:0] idx_q;
  logic [SUM_W-1:0] sum_plus;
  logic             window_last;
  logic             a_take;

  assign sum_plus    = sum_q + SUM_W'(a_scaled_q);
  assign window_last = (idx_q == IDX_LAST);
  assign a_take      = a_valid_q && a_sample_q;

  logic                b_valid_q;
  logic                b_sample_q;
  logic                b_clear_q;
  logic                b_done_q;
  logic [SCALED_W-1:0] b_scaled_q;
  logic [SUM_W-1:0]    b_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      idx_q     <= '0;
      b_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= a_valid_q;
      if (a_take) begin
        if (window_last) begin
          sum_q <= '0;
          idx_q <= '0;
        end else begin
          sum_q <= sum_plus;
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_sample_q <= a_sample_q;
      b_clear_q  <= a_clear_q;
      b_done_q   <= a_take && window_last;
      b_scaled_q <= a_scaled_q;
      b_sum_q    <= sum_plus;
    end
  end

  // ---------------- Stage C: average by reciprocal multiply ----------------
  logic [PROD_W-1:0] avg_prod;

  assign avg_prod = PROD_W'(b_sum_q) * PROD_W'(RECIP);

  logic                c_valid_q;
  logic                c_sample_q;
  logic                c_clear_q;
  logic                c_done_q;
  logic [SCALED_W-1:0] c_scaled_q;
  logic [SCALED_W-1:0] c_avg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (adv) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_sample_q <= b_sample_q;
      c_clear_q  <= b_clear_q;
      c_done_q   <= b_done_q;
      c_scaled_q <= b_scaled_q;
      c_avg_q    <= avg_prod[DIV_SHIFT +: SCALED_W];
    end
  end

  // ---------------- Stage D: rise run, event, blinker, result ----------------
  logic [SCALED_W-1:0] scaled_q,   scaled_d;
  logic [SCALED_W-1:0] avg_q,      avg_d;
  logic [CHANGE_W-1:0] change_q,   change_d;
  logic [RISE_W-1:0]   run_q,      run_d;
  logic                event_q,    event_d;
  logic [COUNT_W-1:0]  count_q,    count_d;
  logic                blink_en_q, blink_en_d;
  logic                phase_on_q, phase_on_d;
  logic [HALF_W-1:0]   timer_q,    timer_d;
  logic [HALF_W-1:0]   timer_base;
  pins_t               pins_q,     pins_d;

  always_comb begin
    scaled_d   = scaled_q;
    avg_d      = avg_q;
    change_d   = change_q;
    run_d      = run_q;
    event_d    = event_q;
    count_d    = count_q;
    blink_en_d = blink_en_q;
    phase_on_d = phase_on_q;
    pins_d     = pins_q;
    timer_base = timer_q;

    // Drop the event flag before this tick can raise it again
    if (c_clear_q) begin
      event_d = 1'b0;
    end
    if (c_sample_q) begin
      scaled_d = c_scaled_q;
    end

    // Close a window: extend or end the rise run
    if (c_done_q) begin
      avg_d    = c_avg_q;
      change_d = CHANGE_W'(c_avg_q) - CHANGE_W'(avg_q);
      if ((c_avg_q > avg_q) && (avg_q != '0)) begin
        if (run_q != RUN_MAX) begin
          run_d = run_q + 1'b1;
          if (run_d == rise_windows_q) begin
            event_d    = 1'b1;
            blink_en_d = 1'b1;
            if (count_q != COUNT_MAX) begin
              count_d = count_q + 1'b1;
            end
          end
        end
      end else begin
        run_d = '0;
      end
    end

    // Fire the blink timer: toggle drive and brake, or hold the LED on
    if (timer_q >= blink_half_q) begin
      timer_base = '0;
      if (blink_en_d) begin
        if (phase_on_q) begin
          phase_on_d = 1'b0;
          pins_d     = PINS_BRAKE;
        end else begin
          phase_on_d = 1'b1;
          pins_d     = PINS_DRIVE;
        end
      end else begin
        pins_d.led = 1'b1;
      end
    end
    timer_d = timer_base + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      scaled_q    <= '0;
      avg_q       <= '0;
      change_q    <= '0;
      run_q       <= '0;
      event_q     <= 1'b0;
      count_q     <= '0;
      blink_en_q  <= 1'b0;
      phase_on_q  <= 1'b0;
      timer_q     <= '0;
      pins_q      <= '0;
    end else if (adv) begin
      out_valid_q <= c_valid_q;
      if (c_valid_q) begin
        scaled_q   <= scaled_d;
        avg_q      <= avg_d;
        change_q   <= change_d;
        run_q      <= run_d;
        event_q    <= event_d;
        count_q    <= count_d;
        blink_en_q <= blink_en_d;
        phase_on_q <= phase_on_d;
        timer_q    <= timer_d;
        pins_q     <= pins_d;
      end
    end
  end

  // Result beat straight from the state registers
  assign out_o.valid           = out_valid_q;
  assign out_o.scaled_pressure = scaled_q;
  assign out_o.window_average  = avg_q;
  assign out_o.average_change  = change_q;
  assign out_o.deploy_event    = event_q;
  assign out_o.deploy_count    = count_q;
  assign out_o.led_out         = pins_q.led;
  assign out_o.motor_in1       = pins_q.in1;
  assign out_o.motor_in2       = pins_q.in2;

endmodule

`default_nettype wire

/* src/pad_checker.sv */
// Port-level checker for the pressure apogee detector, bound to the top level
`default_nettype none

`include "pressure_apogee_detector_assert.svh"

module pad_checker
  import pad_pkg::*;
(
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic [SCALED_W-1:0]        window_average_i,
  input wire logic signed [CHANGE_W-1:0] average_change_i,
  input wire logic                       deploy_event_i,
  input wire logic [COUNT_W-1:0]         deploy_count_i,
  input wire logic                       led_out_i,
  input wire logic                       motor_in1_i,
  input wire logic                       motor_in2_i
);

  logic                       out_beat;
  logic [COUNT_W-1:0]         last_count_q;
  logic [SCALED_W-1:0]        last_avg_q;
  logic signed [CHANGE_W-1:0] expected_change;

  assign out_beat        = out_valid_i && out_ready_i;
  assign expected_change = $signed(CHANGE_W'(window_average_i))
                         - $signed(CHANGE_W'(last_avg_q));

  // Remember what the last result beat carried
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q <= '0;
      last_avg_q   <= '0;
    end else if (out_beat) begin
      last_count_q <= deploy_count_i;
      last_avg_q   <= window_average_i;
    end
  end

  `PAD_ASSERT(count_never_drops, clk_i, rst_ni, out_beat, deploy_count_i >= last_count_q)
  `PAD_ASSERT(count_step_raises_event, clk_i, rst_ni, out_beat && (deploy_count_i != last_count_q), deploy_event_i && (deploy_count_i == last_count_q + 1'b1))
  `PAD_ASSERT(change_follows_average, clk_i, rst_ni, out_beat && (window_average_i != last_avg_q), average_change_i == expected_change)
  `PAD_ASSERT(motor_only_after_deploy, clk_i, rst_ni, out_valid_i && (motor_in1_i || motor_in2_i), (deploy_count_i != '0) && !(motor_in1_i && led_out_i))
  `PAD_ASSERT_NEXT(stalled_beat_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(deploy_count_i) && $stable(window_average_i))

endmodule

bind pressure_apogee_detector pad_checker u_pad_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .window_average_i (out_o.window_average),
  .average_change_i (out_o.average_change),
  .deploy_event_i   (out_o.deploy_event),
  .deploy_count_i   (out_o.deploy_count),
  .led_out_i        (out_o.led_out),
  .motor_in1_i      (out_o.motor_in1),
  .motor_in2_i      (out_o.motor_in2)
);

`default_nettype wire
